// ----- rtl/tep_pkg.sv -----
// ----------------------------------------------------------------------------
// tep_pkg: shared types and constants of the timed event player
// Input and result codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam int MAX_EVENTS_DEF = 64;
  localparam int RESULT_CAP     = 64;
  localparam int CAP_W          = $clog2(RESULT_CAP + 1);

  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int TIME_W = 24;
  localparam int VAL_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_PLAY   = 3'd1,
    FN_TICK   = 3'd2,
    FN_STOP   = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_EMIT    = 2'd0,
    ST_NO_PLAY = 2'd1,
    ST_NO_STOP = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

endpackage

// ----- rtl/tep_store.sv -----
// ----------------------------------------------------------------------------
// tep_store: event store
// One write port and one registered read port over onset and value pairs.
// ----------------------------------------------------------------------------
module tep_store #(
  parameter int DEPTH = tep_pkg::MAX_EVENTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tep_pkg::TIME_W-1:0] wonset,
  input  logic [tep_pkg::VAL_W-1:0]  wvalue,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tep_pkg::TIME_W-1:0] ronset,
  output logic [tep_pkg::VAL_W-1:0]  rvalue
);
  import tep_pkg::*;

  logic [TIME_W-1:0] onsets [DEPTH];
  logic [VAL_W-1:0]  values [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      onsets[waddr] <= wonset;
      values[waddr] <= wvalue;
    end
  end

  // read data holds while re is low, so a stalled scan keeps its entry
  always_ff @(posedge clk) begin
    if (re) begin
      ronset <= onsets[raddr];
      rvalue <= values[raddr];
    end
  end

endmodule

// ----- rtl/timed_event_player.sv -----
// ----------------------------------------------------------------------------
// timed_event_player: millisecond event sequencer
// Stores onset and value pairs in insertion order and emits the events whose
// onset matches the new play time on each play and tick, one compare per stored entry.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | func onset value has_start start_time
//  result   | out_valid/out_ready | status event_value event_time
//           |                     | still_playing last
//
// insert, stop, clear and ignored codes give no result unless they fail; an error
// result is held and handed out from the drain state. play and tick scan the store:
// the single store read port and the onset compare behind it look at one stored entry
// per cycle, then the last compare and the hand-off of the held match follow.
// a held match behind an untaken output result pauses the scan until it is taken.
// reset clears all control state; store contents stay undefined, no sweep.
module timed_event_player #(
  parameter int MAX_EVENTS = tep_pkg::MAX_EVENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tep_pkg::FUNC_W-1:0] func,
  input  logic [tep_pkg::TIME_W-1:0] onset,
  input  logic [tep_pkg::VAL_W-1:0]  value,
  input  logic                       has_start,
  input  logic [tep_pkg::TIME_W-1:0] start_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tep_pkg::STAT_W-1:0] status,
  output logic [tep_pkg::VAL_W-1:0]  event_value,
  output logic [tep_pkg::TIME_W-1:0] event_time,
  output logic                       still_playing,
  output logic                       last
);
  import tep_pkg::*;

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);

  state_t state, state_next;

  logic [CW-1:0]     event_count;
  logic [TIME_W-1:0] latest_onset;
  logic [TIME_W-1:0] play_time;
  logic              running;
  logic              ever_started;
  logic              table_present;

  logic [CW-1:0]     idx;
  logic              rd_vld;
  logic [CAP_W-1:0]  match_cnt;

  logic              pend_valid;
  logic [STAT_W-1:0] pend_status;
  logic [VAL_W-1:0]  pend_value;
  logic [TIME_W-1:0] pend_time;

  logic [TIME_W-1:0] rd_onset;
  logic [VAL_W-1:0]  rd_value;

  logic              acc, full, do_scan, err, wr_en;
  logic [STAT_W-1:0] err_code;
  logic [TIME_W-1:0] tick_base, tick_time;
  logic              out_free, advance, issue, hit, move_mid, move_end;

  // ---- input decode ----
  always_comb begin
    acc       = in_valid && in_ready;
    full      = (event_count == CW'(MAX_EVENTS));
    tick_base = (func == FN_PLAY) ? (has_start ? start_time : '0) : play_time;
    tick_time = tick_base + TIME_W'(1);
    do_scan   = 1'b0;
    err       = 1'b0;
    err_code  = ST_FULL;
    wr_en     = 1'b0;
    unique case (func)
      FN_INSERT: begin
        wr_en = acc && !full;
        err   = acc && full;
      end
      FN_PLAY: begin
        do_scan  = acc && table_present;
        err      = acc && !table_present;
        err_code = ST_NO_PLAY;
      end
      FN_TICK: begin
        do_scan = acc && running;
      end
      FN_STOP: begin
        err      = acc && !ever_started;
        err_code = ST_NO_STOP;
      end
      default: begin
      end
    endcase
  end

  // ---- sequencer next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (do_scan) state_next = S_SCAN;
        else if (err) state_next = S_DRAIN;
      end
      S_SCAN: begin
        if (advance && !issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    in_ready = (state == S_IDLE);
    out_free = !out_valid || out_ready;
    advance  = !pend_valid || out_free;
    issue    = 1'b0;
    hit      = 1'b0;
    move_end = 1'b0;
    unique case (state)
      S_SCAN: begin
        issue = advance && (idx < event_count) && (match_cnt < CAP_W'(RESULT_CAP));
        hit   = advance && rd_vld && (rd_onset == play_time)
                && (match_cnt < CAP_W'(RESULT_CAP));
      end
      S_DRAIN: begin
        move_end = pend_valid && out_free;
      end
      default: begin
      end
    endcase
    // a new match pushes the held one out, which is then known not to be last
    move_mid = hit && pend_valid;
  end

  tep_store #(
    .DEPTH (MAX_EVENTS),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (event_count[AW-1:0]),
    .wonset (onset),
    .wvalue (value),
    .re     (issue),
    .raddr  (idx[AW-1:0]),
    .ronset (rd_onset),
    .rvalue (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- player state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      event_count   <= '0;
      latest_onset  <= '0;
      play_time     <= '0;
      running       <= 1'b0;
      ever_started  <= 1'b0;
      table_present <= 1'b0;
    end else if (acc) begin
      case (func)
        FN_INSERT: begin
          if (!full) begin
            event_count   <= event_count + CW'(1);
            table_present <= 1'b1;
            if (onset > latest_onset) latest_onset <= onset;
          end
        end
        FN_PLAY: begin
          if (!table_present) begin
            play_time <= '0;
          end else begin
            play_time    <= tick_time;
            ever_started <= 1'b1;
            running      <= (latest_onset > tick_time);
          end
        end
        FN_TICK: begin
          if (running) begin
            play_time <= tick_time;
            running   <= (latest_onset > tick_time);
          end
        end
        FN_STOP: begin
          if (ever_started) running <= 1'b0;
        end
        FN_CLEAR: begin
          running       <= 1'b0;
          event_count   <= '0;
          latest_onset  <= '0;
          table_present <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---- scan counters ----
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_vld    <= 1'b0;
      match_cnt <= '0;
    end else if (do_scan) begin
      idx       <= '0;
      rd_vld    <= 1'b0;
      match_cnt <= '0;
    end else if (state == S_SCAN && advance) begin
      rd_vld <= issue;
      if (issue) idx <= idx + CW'(1);
      if (hit) match_cnt <= match_cnt + CAP_W'(1);
    end
  end

  // ---- held result, one match behind the scan ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (err || hit) begin
      pend_valid <= 1'b1;
    end else if (move_end) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err) begin
      pend_status <= err_code;
      pend_value  <= '0;
      pend_time   <= '0;
    end else if (hit) begin
      pend_status <= ST_EMIT;
      pend_value  <= rd_value;
      pend_time   <= play_time;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_mid || move_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_mid || move_end) begin
      status        <= pend_status;
      event_value   <= pend_value;
      event_time    <= pend_time;
      still_playing <= running;
      last          <= move_end;
    end
  end

  // ---- assertions ----
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("held result left over while taking a new item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CW'(MAX_EVENTS))
    else $error("event count beyond store depth");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && (status != ST_EMIT) |-> last)
    else $error("error result not marked last");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    match_cnt <= CAP_W'(RESULT_CAP))
    else $error("match count beyond result cap");

endmodule

// ----- bench/tb_timed_event_player.sv -----
// ----------------------------------------------------------------------------
// tb_timed_event_player: self-checking bench for the timed event player
// A queue of commands feeds a bursty driver. A cycle-free predictor keeps its
// own event table and play clock, and works out the items each accepted
// command must produce. The monitor pops them in order and compares each field
// while the receiver stalls on its own pattern and now and then holds off long.
// ----------------------------------------------------------------------------
module tb_timed_event_player;
  timeunit 1ns;
  timeprecision 1ps;

  import tep_pkg::*;

  localparam int RANDOM_CMDS = 470;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 100;
  localparam int FN_W        = FUNC_W;

  localparam logic [FUNC_W-1:0] FN_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [TIME_W-1:0] onset_ms;
    logic [VAL_W-1:0]  handle;
    logic              has_start;
    logic [TIME_W-1:0] start_ms;
  } player_cmd_t;

  typedef struct {
    status_t           st;
    logic [VAL_W-1:0]  handle;
    logic [TIME_W-1:0] at_ms;
    logic              playing;
    logic              tail;
  } event_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func       = '0;
  logic [TIME_W-1:0] onset      = '0;
  logic [VAL_W-1:0]  value      = '0;
  logic              has_start  = 1'b0;
  logic [TIME_W-1:0] start_time = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  event_value;
  logic [TIME_W-1:0] event_time;
  logic              still_playing;
  logic              last;

  timed_event_player u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .onset         (onset),
    .value         (value),
    .has_start     (has_start),
    .start_time    (start_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .event_value   (event_value),
    .event_time    (event_time),
    .still_playing (still_playing),
    .last          (last)
  );

  always #6 clk = ~clk;

  player_cmd_t pending_cmds[$];
  event_out_t  due_events[$];
  int          mismatches = 0;
  int          results_seen = 0;

  // predictor copy of the player state
  logic [TIME_W-1:0] tbl_onset[MAX_EVENTS_DEF];
  logic [VAL_W-1:0]  tbl_handle[MAX_EVENTS_DEF];
  int                tbl_count = 0;
  logic [TIME_W-1:0] latest_ms = '0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic              playing = 1'b0;
  logic              started = 1'b0;
  logic              have_table = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [TIME_W-1:0] rand_ms();
    logic [31:0] r;
    r = $urandom;
    return r[TIME_W-1:0];
  endfunction

  function automatic logic rand_bit();
    return $urandom_range(0, 1) != 0;
  endfunction

  task automatic push_error(input status_t st);
    event_out_t e;
    e.st = st;
    e.handle = '0;
    e.at_ms = '0;
    e.playing = playing;
    e.tail = 1'b1;
    due_events.push_back(e);
  endtask

  // one millisecond step: emits the matches in table order, last flag on the
  // final one, so each match is held back until the next is known
  task automatic step_clock();
    event_out_t held;
    int         n;
    n = 0;
    clock_ms = clock_ms + 1'b1;
    playing = latest_ms > clock_ms;
    for (int i = 0; i < tbl_count && n < RESULT_CAP; i++) begin
      if (tbl_onset[i] == clock_ms) begin
        if (n > 0) due_events.push_back(held);
        held.st = ST_EMIT;
        held.handle = tbl_handle[i];
        held.at_ms = clock_ms;
        held.playing = playing;
        held.tail = 1'b0;
        n++;
      end
    end
    if (n > 0) begin
      held.tail = 1'b1;
      due_events.push_back(held);
    end
  endtask

  task automatic apply_command(input player_cmd_t c);
    case (c.fn)
      FN_INSERT: begin
        if (tbl_count >= MAX_EVENTS_DEF) begin
          push_error(ST_FULL);
        end else begin
          have_table = 1'b1;
          tbl_onset[tbl_count] = c.onset_ms;
          tbl_handle[tbl_count] = c.handle;
          tbl_count++;
          if (c.onset_ms > latest_ms) latest_ms = c.onset_ms;
        end
      end
      FN_PLAY: begin
        clock_ms = '0;
        if (!have_table) begin
          push_error(ST_NO_PLAY);
        end else begin
          if (c.has_start) clock_ms = c.start_ms;
          started = 1'b1;
          playing = 1'b1;
          step_clock();
        end
      end
      FN_TICK: begin
        if (playing) step_clock();
      end
      FN_STOP: begin
        if (!started) push_error(ST_NO_STOP);
        else playing = 1'b0;
      end
      FN_CLEAR: begin
        playing = 1'b0;
        tbl_count = 0;
        latest_ms = '0;
        have_table = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] on,
                           input logic [VAL_W-1:0] val, input logic hs,
                           input logic [TIME_W-1:0] st);
    player_cmd_t c;
    c.fn = fn;
    c.onset_ms = on;
    c.handle = val;
    c.has_start = hs;
    c.start_ms = st;
    pending_cmds.push_back(c);
  endtask

  // clear, fill every slot, overflow twice, then play into the crowded onset
  task automatic queue_full_table(input bit all_same);
    logic [TIME_W-1:0] at;
    at = TIME_W'($urandom_range(1, 3));
    queue_cmd(FN_CLEAR, rand_ms(), $urandom, rand_bit(), rand_ms());
    for (int i = 0; i < MAX_EVENTS_DEF; i++) begin
      if (!all_same && $urandom_range(0, 5) == 0)
        queue_cmd(FN_INSERT, at + 1'b1, $urandom, rand_bit(), rand_ms());
      else
        queue_cmd(FN_INSERT, at, $urandom, rand_bit(), rand_ms());
    end
    queue_cmd(FN_INSERT, rand_ms(), $urandom, rand_bit(), rand_ms());
    queue_cmd(FN_INSERT, rand_ms(), $urandom, rand_bit(), rand_ms());
    queue_cmd(FN_PLAY, rand_ms(), $urandom, 1'b1, at - 1'b1);
    for (int i = 0; i < 3; i++) queue_cmd(FN_TICK, rand_ms(), $urandom, rand_bit(), rand_ms());
  endtask

  // a score: optional clear, a handful of events near a base time, play, ticks with stray stops, replays and inserts
  task automatic queue_phrase();
    int                n_ev;
    int                span;
    int                n_ticks;
    int                pick;
    logic [TIME_W-1:0] base;
    player_cmd_t       play_cmd;
    if ($urandom_range(0, 99) < 60)
      queue_cmd(FN_CLEAR, rand_ms(), $urandom, rand_bit(), rand_ms());
    n_ev = $urandom_range(1, 12);
    span = $urandom_range(0, 15);
    pick = $urandom_range(0, 9);
    if (pick < 6) base = TIME_W'($urandom_range(0, 300));
    else if (pick < 9) base = rand_ms();
    else base = 24'hFFFFFF - TIME_W'($urandom_range(0, 20));
    for (int i = 0; i < n_ev; i++)
      queue_cmd(FN_INSERT, base + TIME_W'($urandom_range(0, span)), $urandom,
                rand_bit(), rand_ms());
    play_cmd.fn = FN_PLAY;
    play_cmd.onset_ms = rand_ms();
    play_cmd.handle = $urandom;
    if (base < 20 && $urandom_range(0, 2) == 0) begin
      play_cmd.has_start = 1'b0;
      play_cmd.start_ms = rand_ms();
      n_ticks = int'(base) + span + 3;
    end else begin
      play_cmd.has_start = 1'b1;
      play_cmd.start_ms = base - TIME_W'($urandom_range(0, 3));
      n_ticks = span + 5;
    end
    pending_cmds.push_back(play_cmd);
    for (int t = 0; t < n_ticks; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) queue_cmd(FN_STOP, rand_ms(), $urandom, rand_bit(), rand_ms());
      else if (pick < 5) pending_cmds.push_back(play_cmd);
      else if (pick < 8) queue_cmd(FN_INSERT, base + TIME_W'($urandom_range(0, span)),
                                   $urandom, rand_bit(), rand_ms());
      queue_cmd(FN_TICK, rand_ms(), $urandom, rand_bit(), rand_ms());
    end
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      queue_cmd(FN_W'($urandom_range(0, 7)), rand_ms(), $urandom, rand_bit(), rand_ms());
  endtask

  // driver: bursts of random length with random gaps in between
  int          burst_left = 0;
  int          gap_left = 0;
  player_cmd_t active_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_command(active_cmd);
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        active_cmd = pending_cmds.pop_front();
        func       <= active_cmd.fn;
        onset      <= active_cmd.onset_ms;
        value      <= active_cmd.handle;
        has_start  <= active_cmd.has_start;
        start_time <= active_cmd.start_ms;
        in_valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 25);
          gap_left = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // receiver: stall modes of random length, plus long hold-offs with a result
  // waiting so the block backs up into its input
  int       hold_left = 0;
  int       holds_done = 0;
  int       hold_mark = 30;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && out_valid && results_seen >= hold_mark) begin
      hold_left = LONG_HOLD;
      holds_done++;
      hold_mark = hold_mark + 250;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_HALF: out_ready <= rand_bit();
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    event_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected item, status %0d value %h time %h",
                                  status, event_value, event_time));
      end else begin
        want = due_events.pop_front();
        if (status != want.st)
          report_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (event_value != want.handle)
          report_mismatch($sformatf("event_value %h, want %h", event_value, want.handle));
        if (event_time != want.at_ms)
          report_mismatch($sformatf("event_time %h, want %h", event_time, want.at_ms));
        if (still_playing != want.playing)
          report_mismatch($sformatf("still_playing %b, want %b", still_playing, want.playing));
        if (last != want.tail)
          report_mismatch($sformatf("last %b, want %b", last, want.tail));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int target;
    // nothing to stop, nothing to play, idle tick, unused codes
    queue_cmd(FN_STOP, '0, '0, 1'b0, '0);
    queue_cmd(FN_PLAY, '0, '0, 1'b0, '0);
    queue_cmd(FN_TICK, '0, '0, 1'b0, '0);
    queue_cmd(FN_UNUSED_5, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF);
    queue_cmd(FN_UNUSED_6, '0, '0, 1'b0, '0);
    queue_cmd(FN_UNUSED_7, 24'h5A5A5A, 32'hA5A5_A5A5, 1'b1, 24'hA5A5A5);
    // field extremes and the wrap of the play clock
    queue_cmd(FN_INSERT, 24'd2, 32'hFFFF_FFFF, 1'b0, '0);
    queue_cmd(FN_INSERT, 24'd0, 32'h0000_0000, 1'b0, '0);
    queue_cmd(FN_INSERT, 24'hFFFFFF, 32'h8000_0001, 1'b0, '0);
    queue_cmd(FN_PLAY, '0, '0, 1'b1, 24'hFFFFFE);
    queue_cmd(FN_PLAY, '0, '0, 1'b1, 24'hFFFFFF);
    queue_cmd(FN_TICK, '0, '0, 1'b0, '0);
    queue_cmd(FN_TICK, '0, '0, 1'b0, '0);
    queue_cmd(FN_STOP, '0, '0, 1'b0, '0);
    queue_cmd(FN_TICK, '0, '0, 1'b0, '0);
    queue_cmd(FN_CLEAR, '0, '0, 1'b0, '0);
    // stop after a clear stays silent, play on an empty table does not
    queue_cmd(FN_STOP, '0, '0, 1'b0, '0);
    queue_cmd(FN_PLAY, '0, '0, 1'b1, 24'd7);
    queue_cmd(FN_INSERT, 24'd1, 32'h1234_5678, 1'b0, '0);
    queue_cmd(FN_PLAY, '0, '0, 1'b0, 24'hFFFFFF);

    target = pending_cmds.size() + RANDOM_CMDS;
    queue_full_table(1'b1);
    while (pending_cmds.size() < target) begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   queue_full_table(1'b0);
        [2:16]:  queue_noise();
        default: queue_phrase();
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || due_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_events.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived", due_events.size()));
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
